FILE: hw/rtl/ffca_pkg.sv
package ffca_pkg;

	// default store size and the largest size the token fields can carry
	localparam int CELL_COUNT_DEF = 128;
	localparam int MAX_CELLS      = 1024;

	// token field widths, sized for the largest store
	localparam int PW     = $clog2(MAX_CELLS);
	localparam int CW_MAX = $clog2(MAX_CELLS + 1);

	// op codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	// command held steady for the whole scan
	typedef struct packed {
		logic       op;
		logic [7:0] size;
		logic [6:0] start;
	} cmd_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [CW_MAX-1:0] run;
		logic [PW-1:0]     pos;
		logic [CW_MAX-1:0] len;
	} tok_t;

	// one-cycle update broadcast to all cells
	typedef struct packed {
		logic              set;
		logic              clr;
		logic [PW-1:0]     lo;
		logic [PW-1:0]     hi;
		logic [CW_MAX-1:0] len;
	} upd_t;

endpackage

FILE: hw/rtl/ffca_if.sv
// request channel
interface ffca_req_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] request_size;
	logic [6:0] start_cell;

	modport source (output valid, output op, output request_size, output start_cell,
		input ready);
	modport sink (input valid, input op, input request_size, input start_cell,
		output ready);
endinterface

// result channel
interface ffca_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [6:0] block_start;
	logic [7:0] scan_count;
	logic [7:0] occupied_cells;

	modport source (output valid, output status, output block_start, output scan_count,
		output occupied_cells, input ready);
	modport sink (input valid, input status, input block_start, input scan_count,
		input occupied_cells, output ready);
endinterface

FILE: hw/rtl/first_fit_cell_allocator_core.sv
// First-fit allocator over CELL_COUNT cells held in a row of cells.
// An allocate or free launches a scan token that crosses the row one cell per cycle;
// an allocate of size 0 or above CELL_COUNT skips the scan. The result is registered
// once the result slot is free; a new request is taken only after that, when idle.
// Reset (arst_n low, asynchronous): all cells free, no blocks, occupancy 0.
module first_fit_cell_allocator_core #(
	parameter int CELL_COUNT = ffca_pkg::CELL_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ffca_req_if.sink    req,
	ffca_rsp_if.source  rsp
);

	ffca_pkg::cmd_t cmd;
	ffca_pkg::upd_t upd;
	ffca_pkg::tok_t chain_tok [CELL_COUNT+1];

	// sequencer
	ffca_ctrl #(.CELL_COUNT(CELL_COUNT)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cmd      (cmd),
		.upd      (upd),
		.tok_head (chain_tok[0]),
		.tok_tail (chain_tok[CELL_COUNT])
	);

	// row of cells
	for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
		ffca_cell #(.CELL_COUNT(CELL_COUNT), .IDX(g)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.upd     (upd),
			.tok_in  (chain_tok[g]),
			.tok_out (chain_tok[g+1])
		);
	end

endmodule

FILE: hw/rtl/ffca_cell.sv
module ffca_cell #(
	parameter int CELL_COUNT = ffca_pkg::CELL_COUNT_DEF,
	parameter int IDX        = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ffca_pkg::cmd_t  cmd,
	input  ffca_pkg::upd_t  upd,
	input  ffca_pkg::tok_t  tok_in,
	output ffca_pkg::tok_t  tok_out
);

	localparam int CW = $clog2(CELL_COUNT + 1);

	localparam logic [ffca_pkg::PW-1:0]     IDX_P = ffca_pkg::PW'(IDX);
	localparam logic [ffca_pkg::CW_MAX-1:0] IDX_C = ffca_pkg::CW_MAX'(IDX);

	logic          busy_q;
	logic [CW-1:0] len_q;
	ffca_pkg::tok_t tok_q;

	ffca_pkg::tok_t                tok_n;
	logic [ffca_pkg::CW_MAX-1:0]   run_n;
	logic [ffca_pkg::CW_MAX-1:0]   size_w;
	logic                          hit_a;
	logic                          hit_f;
	logic                          in_rng;
	logic                          at_lo;

	// free run length ending here, and the two kinds of hit
	always_comb begin
		size_w = ffca_pkg::CW_MAX'(cmd.size);
		run_n  = busy_q ? '0 : tok_in.run + 1'b1;
		hit_a  = (run_n >= size_w);
		hit_f  = ({3'b000, cmd.start} == IDX_P) && (len_q != '0);
	end

	// token stage
	always_comb begin
		tok_n = tok_in;
		if (tok_in.valid && !tok_in.found) begin
			if (cmd.op == ffca_pkg::OP_ALLOC) begin
				tok_n.run = run_n;
				if (hit_a) begin
					tok_n.found = 1'b1;
					tok_n.pos   = ffca_pkg::PW'(IDX_C + 1'b1 - size_w);
				end
			end else begin
				if (hit_f) begin
					tok_n.found = 1'b1;
					tok_n.len   = ffca_pkg::CW_MAX'(len_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_n;
		end
	end

	assign tok_out = tok_q;

	// range match for the update broadcast
	assign in_rng = (IDX_P >= upd.lo) && (IDX_P <= upd.hi);
	assign at_lo  = (IDX_P == upd.lo);

	// cell state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			len_q  <= '0;
		end else begin
			if (upd.set) begin
				if (in_rng) busy_q <= 1'b1;
				if (at_lo) len_q <= upd.len[CW-1:0];
			end else if (upd.clr) begin
				if (in_rng) busy_q <= 1'b0;
				if (at_lo) len_q <= '0;
			end
		end
	end

endmodule

FILE: hw/rtl/ffca_ctrl.sv
module ffca_ctrl #(
	parameter int CELL_COUNT = ffca_pkg::CELL_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	ffca_req_if.sink        req,
	ffca_rsp_if.source      rsp,
	output ffca_pkg::cmd_t  cmd,
	output ffca_pkg::upd_t  upd,
	output ffca_pkg::tok_t  tok_head,
	input  ffca_pkg::tok_t  tok_tail
);

	localparam int CW = $clog2(CELL_COUNT + 1);
	localparam logic [ffca_pkg::CW_MAX-1:0] N_C = ffca_pkg::CW_MAX'(CELL_COUNT);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD} state_t;

	state_t                       state_q;
	ffca_pkg::cmd_t               cmd_q;
	ffca_pkg::tok_t               tok_q;
	logic [1:0]                   res_status_q;
	logic [ffca_pkg::PW-1:0]      res_start_q;
	logic [ffca_pkg::CW_MAX-1:0]  res_scan_q;
	logic [ffca_pkg::CW_MAX-1:0]  res_len_q;
	logic                         res_apply_q;
	logic [CW-1:0]                busy_total_q;

	logic                         slot_free;
	logic                         commit;
	logic [ffca_pkg::CW_MAX-1:0]  req_size_w;
	logic [ffca_pkg::CW_MAX-1:0]  size_w;
	logic [ffca_pkg::CW_MAX-1:0]  upd_len;
	logic [ffca_pkg::CW_MAX-1:0]  tot_w;
	logic [ffca_pkg::CW_MAX-1:0]  tot_n;

	assign req.ready  = (state_q == S_IDLE);
	assign req_size_w = ffca_pkg::CW_MAX'(req.request_size);
	assign size_w     = ffca_pkg::CW_MAX'(cmd_q.size);
	assign slot_free  = !rsp.valid || rsp.ready;
	assign commit     = (state_q == S_UPD) && slot_free;

	assign cmd      = cmd_q;
	assign tok_head = tok_q;

	// update broadcast and new occupancy
	always_comb begin
		upd_len = (cmd_q.op == ffca_pkg::OP_ALLOC) ? size_w : res_len_q;
		tot_w   = ffca_pkg::CW_MAX'(busy_total_q);
		tot_n   = tot_w;
		if (res_apply_q) begin
			tot_n = (cmd_q.op == ffca_pkg::OP_ALLOC) ? tot_w + upd_len : tot_w - upd_len;
		end
		upd.set = commit && res_apply_q && (cmd_q.op == ffca_pkg::OP_ALLOC);
		upd.clr = commit && res_apply_q && (cmd_q.op == ffca_pkg::OP_FREE);
		upd.lo  = res_start_q;
		upd.hi  = ffca_pkg::PW'(ffca_pkg::CW_MAX'(res_start_q) + upd_len - 1'b1);
		upd.len = upd_len;
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= S_IDLE;
			cmd_q              <= '0;
			tok_q              <= '0;
			res_status_q       <= ffca_pkg::ST_OK;
			res_start_q        <= '0;
			res_scan_q         <= '0;
			res_len_q          <= '0;
			res_apply_q        <= 1'b0;
			busy_total_q       <= '0;
			rsp.valid          <= 1'b0;
			rsp.status         <= ffca_pkg::ST_OK;
			rsp.block_start    <= '0;
			rsp.scan_count     <= '0;
			rsp.occupied_cells <= '0;
		end else begin
			tok_q.valid <= 1'b0;
			if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q.op    <= req.op;
						cmd_q.size  <= req.request_size;
						cmd_q.start <= req.start_cell;
						if (req.op == ffca_pkg::OP_ALLOC &&
							(req_size_w == '0 || req_size_w > N_C)) begin
							// request that cannot fit anywhere: no scan
							res_status_q <= ffca_pkg::ST_NOFIT;
							res_start_q  <= '0;
							res_scan_q   <= '0;
							res_apply_q  <= 1'b0;
							state_q      <= S_UPD;
						end else begin
							tok_q   <= '{valid: 1'b1, found: 1'b0, run: '0, pos: '0, len: '0};
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (tok_tail.valid) begin
						if (cmd_q.op == ffca_pkg::OP_ALLOC) begin
							res_len_q <= '0;
							if (tok_tail.found) begin
								res_status_q <= ffca_pkg::ST_OK;
								res_start_q  <= tok_tail.pos;
								res_scan_q   <= ffca_pkg::CW_MAX'(tok_tail.pos);
								res_apply_q  <= 1'b1;
							end else begin
								res_status_q <= ffca_pkg::ST_NOFIT;
								res_start_q  <= '0;
								res_scan_q   <= N_C - size_w + 1'b1;
								res_apply_q  <= 1'b0;
							end
						end else begin
							res_start_q <= ffca_pkg::PW'(cmd_q.start);
							res_scan_q  <= '0;
							res_len_q   <= tok_tail.len;
							res_apply_q <= tok_tail.found;
							res_status_q <= tok_tail.found ? ffca_pkg::ST_OK
								: ffca_pkg::ST_BADFREE;
						end
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (slot_free) begin
						rsp.valid          <= 1'b1;
						rsp.status         <= res_status_q;
						rsp.block_start    <= (cmd_q.op == ffca_pkg::OP_FREE) ? cmd_q.start
							: res_start_q[6:0];
						rsp.scan_count     <= res_scan_q[7:0];
						rsp.occupied_cells <= tot_n[7:0];
						busy_total_q       <= tot_n[CW-1:0];
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// the token reaches the end of the row only while a scan is running
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_tail.valid |-> state_q == S_SCAN)
		else $error("scan token left the row outside a scan");

	// a launched token goes out together with the entry into the scan state
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		tok_q.valid |-> state_q == S_SCAN)
		else $error("token launched without entering scan");

	// occupancy never exceeds the store
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		ffca_pkg::CW_MAX'(busy_total_q) <= N_C)
		else $error("occupied count above store size");

	// a bad-free status only comes from a free
	a_badfree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && res_status_q == ffca_pkg::ST_BADFREE)
		|-> cmd_q.op == ffca_pkg::OP_FREE && !res_apply_q)
		else $error("bad-free status on an allocate");
`endif

endmodule
